FILE: rtl/rbpe_pkg.sv
// rbpe_pkg: shared widths, command and register codes, stream word layouts
// for the rational b-spline point evaluator
// no dependencies
package rbpe_pkg;

	// default sizes, handed to the top level parameters
	localparam int DEF_MAX_POINTS = 8;
	localparam int DEF_MAX_DEGREE = 3;

	// field widths
	localparam int CMD_W    = 2;
	localparam int SLOT_W   = 4;
	localparam int COORD_W  = 32;
	localparam int WEIGHT_W = 24;
	localparam int KNOT_W   = 17;

	// stream word widths
	localparam int IN_FIELDS_W = SLOT_W + 2 * COORD_W + WEIGHT_W + 2 * KNOT_W;
	localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int IN_PAD_W    = IN_DATA_W - IN_FIELDS_W;
	localparam int OUT_DATA_W  = 2 * COORD_W;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 4;
	localparam logic [1:0] DEGREE_RST = 2'd3;
	localparam logic [3:0] PCOUNT_RST = 4'd4;

	// span ratio divider: Q.24 result, three quotient bits per stage
	localparam int RATIO_FRAC  = 24;
	localparam int RATIO_W     = RATIO_FRAC + 1;
	localparam int DIFF_W      = KNOT_W + 1;
	localparam int RDIV_STEP   = 3;
	localparam int RDIV_STAGES = RATIO_FRAC / RDIV_STEP;
	localparam int RDIV_LAT    = RDIV_STAGES + 1;

	// final point divider: one quotient bit per stage, plus prep and output
	localparam int PDIV_LAT = COORD_W + 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_WRITE_POINT = 2'd0,
		CMD_WRITE_KNOT  = 2'd1,
		CMD_EVAL        = 2'd2
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEGREE      = 1'b0,
		REG_POINT_COUNT = 1'b1
	} reg_idx_t;

	// input word, first field in the lowest bits
	typedef struct packed {
		logic [IN_PAD_W-1:0]       pad;
		logic [KNOT_W-1:0]         param_u;
		logic [KNOT_W-1:0]         knot_value;
		logic [WEIGHT_W-1:0]       point_weight;
		logic signed [COORD_W-1:0] point_y;
		logic signed [COORD_W-1:0] point_x;
		logic [SLOT_W-1:0]         slot;
	} in_word_t;

	// output word
	typedef struct packed {
		logic signed [COORD_W-1:0] curve_y;
		logic signed [COORD_W-1:0] curve_x;
	} out_word_t;

endpackage

FILE: rtl/rbpe_ratio_div.sv
// rbpe_ratio_div: pipelined clamped span ratio, floor(|num|*2^24/|den|) <= 1.0
// zero for a zero span, a zero numerator or opposite signs
// depends on rbpe_pkg
module rbpe_ratio_div
	import rbpe_pkg::*;
(
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [DIFF_W-1:0] num,
	input  logic signed [DIFF_W-1:0] den,
	output logic [RATIO_W-1:0]       q
);

	logic [KNOT_W-1:0]     rem_s  [0:RDIV_STAGES];
	logic [KNOT_W-1:0]     ad_s   [0:RDIV_STAGES];
	logic [RATIO_FRAC-1:0] quo_s  [0:RDIV_STAGES];
	logic                  kill_s [0:RDIV_STAGES];
	logic                  one_s  [0:RDIV_STAGES];
	logic [KNOT_W-1:0]     an_w;
	logic [KNOT_W-1:0]     ad_w;

	// magnitudes and early outs
	always_comb begin
		an_w = num[DIFF_W-1] ? KNOT_W'(-num) : KNOT_W'(num);
		ad_w = den[DIFF_W-1] ? KNOT_W'(-den) : KNOT_W'(den);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= an_w;
			ad_s[0]   <= ad_w;
			quo_s[0]  <= '0;
			kill_s[0] <= (den == '0) || (num == '0) || (num[DIFF_W-1] != den[DIFF_W-1]);
			one_s[0]  <= an_w >= ad_w;
		end
	end

	// restoring division, three quotient bits per stage
	for (genvar gk = 1; gk <= RDIV_STAGES; gk++) begin : g_stage
		logic [KNOT_W-1:0]     r_w;
		logic [KNOT_W:0]       t_w;
		logic [RATIO_FRAC-1:0] qb_w;

		always_comb begin
			r_w  = rem_s[gk-1];
			qb_w = quo_s[gk-1];
			t_w  = '0;
			for (int t = 0; t < RDIV_STEP; t++) begin
				t_w = {r_w, 1'b0};
				if (t_w >= {1'b0, ad_s[gk-1]}) begin
					r_w  = KNOT_W'(t_w - {1'b0, ad_s[gk-1]});
					qb_w = {qb_w[RATIO_FRAC-2:0], 1'b1};
				end else begin
					r_w  = KNOT_W'(t_w);
					qb_w = {qb_w[RATIO_FRAC-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[gk]  <= r_w;
				ad_s[gk]   <= ad_s[gk-1];
				quo_s[gk]  <= qb_w;
				kill_s[gk] <= kill_s[gk-1];
				one_s[gk]  <= one_s[gk-1];
			end
		end
	end

	// clamp and zero
	always_comb begin
		if (kill_s[RDIV_STAGES]) begin
			q = '0;
		end else if (one_s[RDIV_STAGES]) begin
			q = RATIO_W'(1) << RATIO_FRAC;
		end else begin
			q = {1'b0, quo_s[RDIV_STAGES]};
		end
	end

endmodule

FILE: rtl/rbpe_point_div.sv
// rbpe_point_div: pipelined signed quotient of the x and y sums by the weight sum,
// truncated toward zero and saturated to 32 bits, origin and flag on a zero sum
// depends on rbpe_pkg
module rbpe_point_div
	import rbpe_pkg::*;
#(
	parameter int NUMW = 64,
	parameter int DENW = 31
) (
	input  logic                      clk,
	input  logic                      en,
	input  logic signed [NUMW-1:0]    num_x,
	input  logic signed [NUMW-1:0]    num_y,
	input  logic [DENW-1:0]           den,
	output logic signed [COORD_W-1:0] res_x,
	output logic signed [COORD_W-1:0] res_y,
	output logic                      res_zero
);

	localparam int CW = ((NUMW > DENW + COORD_W) ? NUMW : DENW + COORD_W) + 1;
	localparam logic [COORD_W-1:0] POS_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic [COORD_W-1:0] NEG_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	logic [NUMW-1:0]    rem_s  [0:COORD_W][0:1];
	logic [COORD_W-1:0] quo_s  [0:COORD_W][0:1];
	logic               neg_s  [0:COORD_W][0:1];
	logic               sat_s  [0:COORD_W][0:1];
	logic [DENW-1:0]    den_s  [0:COORD_W];
	logic               zero_s [0:COORD_W];
	logic [NUMW-1:0]    abs_w  [0:1];
	logic               neg_w  [0:1];
	logic [COORD_W-1:0] fin_w  [0:1];

	// magnitudes, signs and overflow check
	always_comb begin
		neg_w[0] = num_x[NUMW-1];
		neg_w[1] = num_y[NUMW-1];
		abs_w[0] = neg_w[0] ? NUMW'(-num_x) : NUMW'(num_x);
		abs_w[1] = neg_w[1] ? NUMW'(-num_y) : NUMW'(num_y);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s[0]  <= den;
			zero_s[0] <= den == '0;
			for (int l = 0; l < 2; l++) begin
				rem_s[0][l] <= abs_w[l];
				quo_s[0][l] <= '0;
				neg_s[0][l] <= neg_w[l];
				sat_s[0][l] <= CW'(abs_w[l]) >= (CW'(den) << COORD_W);
			end
		end
	end

	// one quotient bit per stage, most significant first
	for (genvar gk = 1; gk <= COORD_W; gk++) begin : g_stage
		logic [CW-1:0] dsh_w;
		logic          ge_w [0:1];

		always_comb begin
			dsh_w = CW'(den_s[gk-1]) << (COORD_W - gk);
			for (int l = 0; l < 2; l++) begin
				ge_w[l] = CW'(rem_s[gk-1][l]) >= dsh_w;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[gk]  <= den_s[gk-1];
				zero_s[gk] <= zero_s[gk-1];
				for (int l = 0; l < 2; l++) begin
					rem_s[gk][l] <= ge_w[l] ? NUMW'(CW'(rem_s[gk-1][l]) - dsh_w)
						: rem_s[gk-1][l];
					quo_s[gk][l] <= quo_s[gk-1][l] | (ge_w[l] ? (COORD_W'(1) << (COORD_W - gk))
						: '0);
					neg_s[gk][l] <= neg_s[gk-1][l];
					sat_s[gk][l] <= sat_s[gk-1][l];
				end
			end
		end
	end

	// sign and saturation
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			if (zero_s[COORD_W]) begin
				fin_w[l] = '0;
			end else if (!neg_s[COORD_W][l]) begin
				fin_w[l] = (sat_s[COORD_W][l] || quo_s[COORD_W][l][COORD_W-1]) ? POS_MAX
					: quo_s[COORD_W][l];
			end else begin
				fin_w[l] = (sat_s[COORD_W][l] || (quo_s[COORD_W][l] > NEG_MIN)) ? NEG_MIN
					: COORD_W'(-quo_s[COORD_W][l]);
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (en) begin
			res_x    <= fin_w[0];
			res_y    <= fin_w[1];
			res_zero <= zero_s[COORD_W];
		end
	end

endmodule

FILE: rtl/rational_bspline_point_eval_top.sv
// rational_bspline_point_eval_top: nurbs curve point evaluator, table writes and
// a deep pipeline for evaluation; uses rbpe_pkg, rbpe_ratio_div, rbpe_point_div
//
//  channel  dir  handshake         payload
//  s        in   s_tvalid/tready   tdata: slot, point_x, point_y, point_weight,
//                                  knot_value, param_u; tuser: command
//  m        out  m_tvalid/tready   tdata: curve_x, curve_y; tuser: zero_weight
//  cfg      in   cfg_we            cfg_index, cfg_data (degree, point_count)
//
// evaluate words enter one per cycle while m_tready does not hold the pipeline; they pass
//   the entry stage, the span ratio dividers, the recursion levels, the weighted products,
//   the adder tree and the 32-step point divider
// a table write waits until no evaluate is in flight
// the whole pipeline holds while a result waits on m_tready; nothing is dropped
// reset clears the valid bits and the configuration registers only
module rational_bspline_point_eval_top
	import rbpe_pkg::*;
#(
	parameter int MAX_POINTS = DEF_MAX_POINTS,
	parameter int MAX_DEGREE = DEF_MAX_DEGREE
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // slot, point_x, point_y, point_weight, knot_value, param_u
	input  logic [CMD_W-1:0]      s_tuser,  // command
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,  // curve_x, curve_y
	output logic [0:0]            m_tuser,  // zero_weight
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int NB   = MAX_POINTS + MAX_DEGREE;
	localparam int KD   = NB + 1;
	localparam int BW   = RATIO_FRAC + 1 + MAX_DEGREE;
	localparam int LV   = $clog2(MAX_POINTS);
	localparam int LN   = 1 << LV;
	localparam int PRW  = COORD_W + BW + 1;
	localparam int NUMW = PRW + LV;
	localparam int DENW = BW + LV;
	localparam int WPW  = WEIGHT_W + BW;
	localparam int RPW  = RATIO_W + BW + 1;
	localparam int NW   = $clog2(MAX_POINTS + 1);
	localparam int PW   = $clog2(MAX_DEGREE + 1);
	localparam int CNTW = $clog2(NB + 1);
	localparam int LAT  = 1 + RDIV_LAT + MAX_DEGREE + 2 + LV + PDIV_LAT;
	localparam logic [BW-1:0] ONE_B = BW'(1) << RATIO_FRAC;

	in_word_t  in_w;
	cmd_t      cmd_w;
	out_word_t out_w;

	logic           en;
	logic           busy;
	logic           wr_cmd;
	logic           acc;
	logic [LAT-1:0] vld_q;

	logic [1:0]      degree_q;
	logic [3:0]      pcount_q;
	logic [NW-1:0]   n_w;
	logic [PW-1:0]   p_w;
	logic [CNTW-1:0] count_w;

	logic signed [COORD_W-1:0] ptx_q [0:MAX_POINTS-1];
	logic signed [COORD_W-1:0] pty_q [0:MAX_POINTS-1];
	logic [WEIGHT_W-1:0]       ptw_q [0:MAX_POINTS-1];
	logic [KNOT_W-1:0]         knot_q [0:KD-1];

	logic [KNOT_W-1:0] u_s1;
	logic [NB-1:0]     b0_s1;
	logic [NB-1:0]     b0_d_s [0:RDIV_LAT-1];

	logic [RATIO_W-1:0] rat_w  [1:MAX_DEGREE][0:NB-1][0:1];
	logic [RATIO_W-1:0] rat_in [1:MAX_DEGREE][1:MAX_DEGREE][0:NB-1][0:1];
	logic [RATIO_W-1:0] rat_s  [1:MAX_DEGREE][1:MAX_DEGREE][0:NB-1][0:1];
	logic [BW-1:0]      bas_in [1:MAX_DEGREE][0:NB-1];
	logic [BW-1:0]      bas_nx [1:MAX_DEGREE][0:NB-1];
	logic [BW-1:0]      bas_s  [1:MAX_DEGREE][0:NB-1];

	logic [BW-1:0]            wb_s  [0:MAX_POINTS-1];
	logic signed [PRW-1:0]    px_s  [0:MAX_POINTS-1];
	logic signed [PRW-1:0]    py_s  [0:MAX_POINTS-1];
	logic [BW-1:0]            wd_s  [0:MAX_POINTS-1];
	logic signed [NUMW-1:0]   tx_c  [0:LN-1];
	logic signed [NUMW-1:0]   ty_c  [0:LN-1];
	logic [DENW-1:0]          td_c  [0:LN-1];
	logic signed [NUMW-1:0]   tx_s  [1:LV][0:LN-1];
	logic signed [NUMW-1:0]   ty_s  [1:LV][0:LN-1];
	logic [DENW-1:0]          td_s  [1:LV][0:LN-1];

	logic signed [COORD_W-1:0] res_x;
	logic signed [COORD_W-1:0] res_y;
	logic                      res_zero;

	// input word and handshake
	assign in_w   = in_word_t'(s_tdata);
	assign cmd_w  = cmd_t'(s_tuser);
	assign en     = !m_tvalid || m_tready;
	assign busy   = |vld_q;
	assign wr_cmd = (cmd_w == CMD_WRITE_POINT) || (cmd_w == CMD_WRITE_KNOT);
	assign s_tready = en && !(wr_cmd && busy);
	assign acc    = s_tvalid && s_tready;

	// valid bits travel with the words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], acc && (cmd_w == CMD_EVAL)};
		end
	end
	assign m_tvalid = vld_q[LAT-1];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q <= DEGREE_RST;
			pcount_q <= PCOUNT_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_DEGREE:      degree_q <= cfg_data[1:0];
				REG_POINT_COUNT: pcount_q <= cfg_data[3:0];
				default:         ;
			endcase
		end
	end

	// clamped point count, degree and basis count
	always_comb begin
		n_w     = (int'(pcount_q) > MAX_POINTS) ? NW'(MAX_POINTS) : NW'(pcount_q);
		p_w     = (int'(degree_q) > MAX_DEGREE) ? PW'(MAX_DEGREE) : PW'(degree_q);
		count_w = CNTW'(n_w) + CNTW'(p_w);
	end

	// control point and knot tables
	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_POINTS; i++) begin
			if (acc && (cmd_w == CMD_WRITE_POINT) && (int'(in_w.slot) == i)) begin
				ptx_q[i] <= in_w.point_x;
				pty_q[i] <= in_w.point_y;
				ptw_q[i] <= in_w.point_weight;
			end
		end
		for (int i = 0; i < KD; i++) begin
			if (acc && (cmd_w == CMD_WRITE_KNOT) && (int'(in_w.slot) == i)) begin
				knot_q[i] <= in_w.knot_value;
			end
		end
	end

	// entry stage: u and degree-zero span flags
	always_ff @(posedge clk) begin
		if (en) begin
			u_s1 <= in_w.param_u;
			for (int j = 0; j < NB; j++) begin
				b0_s1[j] <= (j < int'(count_w)) && (knot_q[j] <= in_w.param_u)
					&& (in_w.param_u < knot_q[j+1]);
			end
		end
	end

	// degree-zero flags wait for the ratio dividers
	always_ff @(posedge clk) begin
		if (en) begin
			b0_d_s[0] <= b0_s1;
			for (int k = 1; k < RDIV_LAT; k++) begin
				b0_d_s[k] <= b0_d_s[k-1];
			end
		end
	end

	// span ratio dividers, two per basis term and level where gj < NB - gd
	for (genvar gd = 1; gd <= MAX_DEGREE; gd++) begin : g_rlvl
		for (genvar gj = 0; gj < NB; gj++) begin : g_rj
			if (gj < NB - gd) begin : g_on
				logic signed [DIFF_W-1:0] n1_w, d1_w, n2_w, d2_w;

				assign n1_w = $signed({1'b0, u_s1}) - $signed({1'b0, knot_q[gj]});
				assign d1_w = $signed({1'b0, knot_q[gj+gd]}) - $signed({1'b0, knot_q[gj]});
				assign n2_w = $signed({1'b0, knot_q[gj+gd+1]}) - $signed({1'b0, u_s1});
				assign d2_w = $signed({1'b0, knot_q[gj+gd+1]}) - $signed({1'b0, knot_q[gj+1]});

				rbpe_ratio_div u_r1 (
					.clk (clk),
					.en  (en),
					.num (n1_w),
					.den (d1_w),
					.q   (rat_w[gd][gj][0])
				);

				rbpe_ratio_div u_r2 (
					.clk (clk),
					.en  (en),
					.num (n2_w),
					.den (d2_w),
					.q   (rat_w[gd][gj][1])
				);
			end else begin : g_off
				assign rat_w[gd][gj][0] = '0;
				assign rat_w[gd][gj][1] = '0;
			end
		end
	end

	// recursion level inputs
	always_comb begin
		for (int j = 0; j < NB; j++) begin
			bas_in[1][j] = b0_d_s[RDIV_LAT-1][j] ? ONE_B : '0;
		end
		rat_in[1] = rat_w;
		for (int k = 2; k <= MAX_DEGREE; k++) begin
			bas_in[k] = bas_s[k-1];
			rat_in[k] = rat_s[k-1];
		end
	end

	// one recursion level per stage
	for (genvar gk = 1; gk <= MAX_DEGREE; gk++) begin : g_rec
		for (genvar gj = 0; gj < NB; gj++) begin : g_b
			if (gj < NB - gk) begin : g_upd
				logic [RPW-1:0] sum_w;

				assign sum_w = RPW'(RPW'(rat_in[gk][gk][gj][0]) * RPW'(bas_in[gk][gj]))
					+ RPW'(RPW'(rat_in[gk][gk][gj][1]) * RPW'(bas_in[gk][gj+1]));
				assign bas_nx[gk][gj] = ((gk <= int'(p_w)) && ((gj + gk) < int'(count_w)))
					? BW'(sum_w >> RATIO_FRAC) : bas_in[gk][gj];
			end else begin : g_keep
				assign bas_nx[gk][gj] = bas_in[gk][gj];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 1; k <= MAX_DEGREE; k++) begin
				bas_s[k] <= bas_nx[k];
				rat_s[k] <= rat_in[k];
			end
		end
	end

	// weighted basis, then coordinate products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < MAX_POINTS; j++) begin
				wb_s[j] <= (j < int'(n_w))
					? BW'((WPW'(ptw_q[j]) * WPW'(bas_s[MAX_DEGREE][j])) >> RATIO_FRAC) : '0;
				px_s[j] <= PRW'(ptx_q[j]) * $signed({1'b0, wb_s[j]});
				py_s[j] <= PRW'(pty_q[j]) * $signed({1'b0, wb_s[j]});
				wd_s[j] <= wb_s[j];
			end
		end
	end

	// adder tree leaves
	always_comb begin
		for (int i = 0; i < LN; i++) begin
			tx_c[i] = '0;
			ty_c[i] = '0;
			td_c[i] = '0;
			if (i < MAX_POINTS) begin
				tx_c[i] = NUMW'(px_s[i]);
				ty_c[i] = NUMW'(py_s[i]);
				td_c[i] = DENW'(wd_s[i]);
			end
		end
	end

	// registered adder tree
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < LN; i++) begin
				if (i < (LN >> 1)) begin
					tx_s[1][i] <= tx_c[2*i] + tx_c[2*i+1];
					ty_s[1][i] <= ty_c[2*i] + ty_c[2*i+1];
					td_s[1][i] <= td_c[2*i] + td_c[2*i+1];
				end else begin
					tx_s[1][i] <= '0;
					ty_s[1][i] <= '0;
					td_s[1][i] <= '0;
				end
			end
			for (int l = 2; l <= LV; l++) begin
				for (int i = 0; i < LN; i++) begin
					if (i < (LN >> l)) begin
						tx_s[l][i] <= tx_s[l-1][2*i] + tx_s[l-1][2*i+1];
						ty_s[l][i] <= ty_s[l-1][2*i] + ty_s[l-1][2*i+1];
						td_s[l][i] <= td_s[l-1][2*i] + td_s[l-1][2*i+1];
					end else begin
						tx_s[l][i] <= '0;
						ty_s[l][i] <= '0;
						td_s[l][i] <= '0;
					end
				end
			end
		end
	end

	// weighted average divide, ends in the output register
	rbpe_point_div #(
		.NUMW (NUMW),
		.DENW (DENW)
	) u_div (
		.clk      (clk),
		.en       (en),
		.num_x    (tx_s[LV][0]),
		.num_y    (ty_s[LV][0]),
		.den      (td_s[LV][0]),
		.res_x    (res_x),
		.res_y    (res_y),
		.res_zero (res_zero)
	);

	assign out_w.curve_x = res_x;
	assign out_w.curve_y = res_y;
	assign m_tdata       = out_w;
	assign m_tuser       = res_zero;

	// table writes never overtake an evaluate in flight
	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && wr_cmd) |-> !busy)
		else $error("table write accepted with evaluate in flight");

	// a waiting result freezes the valid bits of the pipeline
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> $stable(vld_q))
		else $error("pipeline moved while result stalled");

	// zero weight sum gives the origin
	a_zero_origin: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
		else $error("zero weight word with nonzero point");

endmodule

FILE: bench/tb_top.sv
// tb_top: self-checking bench for the rational b-spline point evaluator
// drives register writes, table writes, unknown and evaluate words with bursty traffic, predicts each point
// in fixed point and compares every output word; depends on rbpe_pkg and the top level
module tb_top;
	import rbpe_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NPTS = DEF_MAX_POINTS;
	localparam int NDEG = DEF_MAX_DEGREE;
	localparam int NKNOTS = NPTS + NDEG + 1;
	localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
	localparam longint unsigned ONE_Q24 = 64'd1 << 24;
	localparam int DRAIN_CYCLES = 80;
	localparam longint CYCLE_LIMIT = 1000000;

	typedef struct {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic                      zw;
	} point_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [CMD_W-1:0]      s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [0:0]            m_tuser;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// shadow of the block's tables and registers
	logic [COORD_W-1:0]  px_tab [NPTS];
	logic [COORD_W-1:0]  py_tab [NPTS];
	logic [WEIGHT_W-1:0] pw_tab [NPTS];
	logic [KNOT_W-1:0]   knot_tab [NKNOTS];
	logic [1:0]          cur_degree = DEGREE_RST;
	logic [3:0]          cur_count = PCOUNT_RST;

	point_t expected_points[$];
	int     mismatches = 0;
	longint cycles = 0;
	int     burst_left = 0;
	int     stall_mode = 0;

	rational_bspline_point_eval_top i_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// timeout
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// receiver stall pattern, mode changes now and then
	always @(negedge clk) begin
		if (cycles % 400 == 0)
			stall_mode = $urandom_range(0, 3);
		case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 3) != 0);
			2: m_tready <= ((cycles % 9) < 4);
			default: m_tready <= ($urandom_range(0, 1) == 1);
		endcase
	end

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
		mismatches++;
	endtask

	// clamped span ratio in q.24
	function automatic longint unsigned span_ratio(input longint num, input longint den);
		longint unsigned an, ad, q;
		if (den == 0 || num == 0 || ((num < 0) != (den < 0)))
			return 0;
		an = num < 0 ? -num : num;
		ad = den < 0 ? -den : den;
		q = (an << 24) / ad;
		return q > ONE_Q24 ? ONE_Q24 : q;
	endfunction

	// curve point at parameter u from the shadow tables
	function automatic point_t curve_point(input logic [KNOT_W-1:0] u_in);
		longint unsigned basis [NPTS+NDEG];
		longint unsigned r1, r2;
		longint u, kj, kjd, kj1, kjd1, wb, num_x, num_y, den, qx, qy;
		int n, p, cnt;
		point_t res;
		u = u_in;
		n = cur_count > NPTS ? NPTS : cur_count;
		p = cur_degree > NDEG ? NDEG : cur_degree;
		cnt = n + p;
		num_x = 0;
		num_y = 0;
		den = 0;
		for (int j = 0; j < cnt; j++)
			basis[j] = (knot_tab[j] <= u && u < knot_tab[j+1]) ? ONE_Q24 : 0;
		for (int d = 1; d <= p; d++)
			for (int j = 0; j < cnt - d; j++) begin
				kj = knot_tab[j];
				kjd = knot_tab[j+d];
				kj1 = knot_tab[j+1];
				kjd1 = knot_tab[j+d+1];
				r1 = span_ratio(u - kj, kjd - kj);
				r2 = span_ratio(kjd1 - u, kjd1 - kj1);
				basis[j] = (r1 * basis[j] + r2 * basis[j+1]) >> 24;
			end
		for (int j = 0; j < n; j++) begin
			wb = (longint'(pw_tab[j]) * basis[j]) >> 24;
			num_x += longint'($signed(px_tab[j])) * wb;
			num_y += longint'($signed(py_tab[j])) * wb;
			den += wb;
		end
		if (den == 0) begin
			res.x = '0;
			res.y = '0;
			res.zw = 1'b1;
		end else begin
			qx = num_x / den;
			qy = num_y / den;
			if (qx > 64'sd2147483647) qx = 64'sd2147483647;
			if (qx < -64'sd2147483648) qx = -64'sd2147483648;
			if (qy > 64'sd2147483647) qy = 64'sd2147483647;
			if (qy < -64'sd2147483648) qy = -64'sd2147483648;
			res.x = qx[31:0];
			res.y = qy[31:0];
			res.zw = 1'b0;
		end
		return res;
	endfunction

	// apply one accepted word to the shadow state
	task automatic track_word(input logic [CMD_W-1:0] cmd, input in_word_t w);
		case (cmd)
			CMD_WRITE_POINT: if (w.slot < NPTS) begin
				px_tab[w.slot] = w.point_x;
				py_tab[w.slot] = w.point_y;
				pw_tab[w.slot] = w.point_weight;
			end
			CMD_WRITE_KNOT: if (w.slot < NKNOTS)
				knot_tab[w.slot] = w.knot_value;
			CMD_EVAL: expected_points.push_back(curve_point(w.param_u));
			default: ;
		endcase
	endtask

	// send one word; the sender runs in bursts with gaps between them
	task automatic send_word(input logic [CMD_W-1:0] cmd, input in_word_t w);
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) != 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(negedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= w;
		s_tuser <= cmd;
		do @(posedge clk); while (!s_tready);
		track_word(cmd, w);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (expected_points.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_DEGREE) cur_degree = val[1:0];
		else cur_count = val;
		@(negedge clk);
	endtask

	function automatic in_word_t rand_word();
		in_word_t w;
		w.pad = '0;
		w.slot = SLOT_W'($urandom_range(0, 15));
		w.point_x = $urandom();
		w.point_y = $urandom();
		w.point_weight = WEIGHT_W'($urandom());
		w.knot_value = KNOT_W'($urandom());
		w.param_u = KNOT_W'($urandom());
		return w;
	endfunction

	task automatic put_point(input int slot, input logic [31:0] x, input logic [31:0] y,
			input logic [23:0] wt);
		in_word_t w;
		w = rand_word();
		w.slot = SLOT_W'(slot);
		w.point_x = x;
		w.point_y = y;
		w.point_weight = wt;
		send_word(CMD_WRITE_POINT, w);
	endtask

	task automatic put_knot(input int slot, input int k);
		in_word_t w;
		w = rand_word();
		w.slot = SLOT_W'(slot);
		w.knot_value = KNOT_W'(k);
		send_word(CMD_WRITE_KNOT, w);
	endtask

	task automatic eval_at(input logic [KNOT_W-1:0] u);
		in_word_t w;
		w = rand_word();
		w.param_u = u;
		send_word(CMD_EVAL, w);
	endtask

	// nondecreasing knot vector, sometimes with repeats or an unsorted entry
	task automatic load_knots();
		int k;
		k = $urandom_range(0, 1) ? 0 : $urandom_range(0, 3000);
		for (int i = 0; i < NKNOTS; i++) begin
			if (i > 0) k += ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 9000);
			if (k > 65536) k = 65536;
			put_knot(i, k);
		end
		if ($urandom_range(0, 5) == 0)
			put_knot($urandom_range(0, NKNOTS - 1), $urandom_range(0, 131071));
	endtask

	function automatic logic [KNOT_W-1:0] pick_u();
		int used;
		used = (cur_count > NPTS ? NPTS : cur_count) + (cur_degree > NDEG ? NDEG : cur_degree);
		case ($urandom_range(0, 19))
			0, 1: return knot_tab[$urandom_range(0, used)];
			2: return knot_tab[used];
			3: return 17'd0;
			4: return 17'd65536;
			5: return KNOT_W'($urandom());
			default: return KNOT_W'($urandom_range(knot_tab[0], knot_tab[used]));
		endcase
	endfunction

	// every table entry is written before any evaluate
	task automatic test_fill_tables();
		put_point(0, 32'h8000_0000, 32'h7FFF_FFFF, 24'hFF_FFFF);
		put_point(1, 32'h7FFF_FFFF, 32'h8000_0000, 24'h01_0000);
		put_point(2, 32'h0000_0000, 32'hFFFF_FFFF, 24'h00_0000);
		for (int i = 3; i < NPTS; i++)
			put_point(i, $urandom(), $urandom(), WEIGHT_W'($urandom_range(1, 24'hFFFFFF)));
		for (int i = 0; i < NKNOTS; i++)
			put_knot(i, (i * 65536) / (NKNOTS - 1));
	endtask

	// extremes, ignored words and the degenerate parameter cases
	task automatic test_directed();
		in_word_t w;
		eval_at(17'd0);
		eval_at(17'd65536);
		eval_at(knot_tab[NPTS]);
		eval_at(knot_tab[3]);
		eval_at(17'h1FFFF);
		eval_at(17'd30000);
		w = rand_word();
		send_word(CMD_UNKNOWN, w);
		put_point(8 + $urandom_range(0, 7), $urandom(), $urandom(), WEIGHT_W'($urandom()));
		put_knot(12 + $urandom_range(0, 3), $urandom());
		eval_at(17'd20000);
		put_knot(5, 131071);
		eval_at(17'd50000);
		put_knot(5, (5 * 65536) / (NKNOTS - 1));
		put_point(1, 32'h7FFF_FFFF, 32'h8000_0000, 24'h00_0001);
		eval_at(17'd15000);
	endtask

	// one configuration phase of random traffic
	task automatic test_random_phase(input logic [1:0] deg, input logic [3:0] cnt,
			input int items);
		in_word_t w;
		wait_idle();
		write_reg(REG_DEGREE, CFG_DATA_W'(deg));
		write_reg(REG_POINT_COUNT, cnt);
		load_knots();
		for (int i = 0; i < items; i++) begin
			w = rand_word();
			case ($urandom_range(0, 19))
				0: send_word(CMD_WRITE_POINT, w);
				1: begin
					w.slot = SLOT_W'($urandom_range(0, NKNOTS - 1));
					w.knot_value = KNOT_W'($urandom_range(0, 65536));
					send_word(CMD_WRITE_KNOT, w);
				end
				2: send_word($urandom_range(0, 1) ? CMD_UNKNOWN : CMD_WRITE_KNOT, w);
				3: load_knots();
				default: begin
					w.param_u = pick_u();
					send_word(CMD_EVAL, w);
				end
			endcase
		end
	endtask

	// compare each output word with the oldest predicted point
	always @(posedge clk) begin
		point_t want;
		out_word_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (expected_points.size() == 0)
				report("unexpected word x", longint'(got.curve_x), 0);
			else begin
				want = expected_points.pop_front();
				if (got.curve_x !== want.x)
					report("curve_x", longint'(got.curve_x), longint'(want.x));
				if (got.curve_y !== want.y)
					report("curve_y", longint'(got.curve_y), longint'(want.y));
				if (m_tuser[0] !== want.zw)
					report("zero_weight", longint'(m_tuser[0]), longint'(want.zw));
			end
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_fill_tables();
		test_directed();
		test_random_phase(2'd0, 4'd1, 90);
		test_random_phase(2'd3, 4'd8, 120);
		test_random_phase(2'd1, 4'd0, 60);
		test_random_phase(2'd2, 4'd15, 90);
		test_random_phase(2'd3, 4'd1, 60);
		test_random_phase(2'd1, 4'd5, 90);
		test_random_phase(2'd0, 4'd8, 90);
		test_random_phase(2'd2, 4'd3, 90);
		test_random_phase(2'd3, 4'd12, 120);
		test_random_phase(2'd3, 4'd4, 90);
		wait_idle();
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
